// ===== rtl/core/frp_pkg.sv =====
// Shared types, constants and format helpers for the float round-and-pack block.
package frp_pkg;

	localparam int MAN_B16  = 10;
	localparam int MAN_B32  = 23;
	localparam int MAN_B64  = 52;
	localparam int EXP_B16  = 5;
	localparam int EXP_B32  = 8;
	localparam int EXP_B64  = 11;
	localparam int BIAS_B16 = 15;
	localparam int BIAS_B32 = 127;
	localparam int BIAS_B64 = 1023;

	localparam int WORD_W   = 64;
	localparam int MAN_W    = MAN_B64 + 1;
	localparam int FRAME_W  = MAN_B64 + 4;
	localparam int EXP_W    = 13;
	localparam int REXP_W   = EXP_W + 1;
	localparam int BIAS_W   = EXP_B64;
	localparam int EMAX_W   = EXP_B64 + 1;

	localparam logic [2:0] RM_RNE = 3'd0;
	localparam logic [2:0] RM_RNA = 3'd1;
	localparam logic [2:0] RM_RUP = 3'd2;
	localparam logic [2:0] RM_RDN = 3'd3;
	localparam logic [2:0] RM_RTZ = 3'd4;

	typedef enum logic [1:0] {
		FMT_B16 = 2'd0,
		FMT_B32 = 2'd1,
		FMT_B64 = 2'd2
	} fmt_t;

	typedef enum logic [1:0] {
		CLS_NORM,
		CLS_ZERO,
		CLS_OVF,
		CLS_UNF
	} cls_t;

	typedef enum logic [1:0] {
		EXC_NONE = 2'd0,
		EXC_OVF  = 2'd1,
		EXC_UNF  = 2'd2
	} exc_t;

	typedef struct packed {
		logic                      sign;
		fmt_t                      dst;
		logic signed [REXP_W-1:0]  exp;
		logic                      zero;
	} s1_ctl_t;

	typedef struct packed {
		logic               sign;
		fmt_t               dst;
		cls_t               cls;
		logic [BIAS_W-1:0]  exp;
		logic [MAN_W-1:0]   man;
		logic [2:0]         grs;
	} s2_t;

	typedef struct packed {
		logic [WORD_W-1:0]  packed_res;
		exc_t               exc;
	} s3_t;

	// code three maps to binary64
	function automatic fmt_t fmt_decode(input logic [1:0] code);
		fmt_t f;
		unique case (code)
			2'd0:    f = FMT_B16;
			2'd1:    f = FMT_B32;
			default: f = FMT_B64;
		endcase
		return f;
	endfunction

	function automatic logic [BIAS_W-1:0] fmt_bias(input fmt_t f);
		logic [BIAS_W-1:0] b;
		unique case (f)
			FMT_B16: b = BIAS_W'(BIAS_B16);
			FMT_B32: b = BIAS_W'(BIAS_B32);
			default: b = BIAS_W'(BIAS_B64);
		endcase
		return b;
	endfunction

	function automatic logic [EMAX_W-1:0] fmt_emax(input fmt_t f);
		logic [EMAX_W-1:0] e;
		e = {fmt_bias(f), 1'b0};
		return e;
	endfunction

	function automatic logic [MAN_B64-1:0] qnan_frac(input fmt_t f);
		logic [MAN_B64-1:0] q;
		unique case (f)
			FMT_B16: q = MAN_B64'(1) << (MAN_B16 - 1);
			FMT_B32: q = MAN_B64'(1) << (MAN_B32 - 1);
			default: q = MAN_B64'(1) << (MAN_B64 - 1);
		endcase
		return q;
	endfunction

	function automatic logic [WORD_W-1:0] pack_word(input fmt_t f, input logic s,
			input logic [BIAS_W-1:0] e, input logic [MAN_B64-1:0] frac);
		logic [WORD_W-1:0] w;
		unique case (f)
			FMT_B16: w = WORD_W'({s, e[EXP_B16-1:0], frac[MAN_B16-1:0]});
			FMT_B32: w = WORD_W'({s, e[EXP_B32-1:0], frac[MAN_B32-1:0]});
			default: w = {s, e[EXP_B64-1:0], frac[MAN_B64-1:0]};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/frp_if.sv =====
// Valid/ready channel interfaces for operands and packed results.
interface frp_in_if;
	logic                               valid;
	logic                               ready;
	logic                               sign;
	logic signed [frp_pkg::EXP_W-1:0]   exponent;
	logic [frp_pkg::WORD_W-1:0]         significand;
	logic [1:0]                         src_format;
	logic [1:0]                         dst_format;

	modport source(output valid, sign, exponent, significand, src_format, dst_format,
		input ready);
	modport sink(input valid, sign, exponent, significand, src_format, dst_format,
		output ready);
endinterface

interface frp_out_if;
	logic                        valid;
	logic                        ready;
	logic [frp_pkg::WORD_W-1:0]  packed_res;
	logic [1:0]                  exception;

	modport source(output valid, packed_res, exception, input ready);
	modport sink(input valid, packed_res, exception, output ready);
endinterface

// ===== rtl/core/frp_decode.sv =====
// Stage 1 logic: exponent rebias, zero detect and leading-zero count.
module frp_decode #(
	parameter int SIG_WIDTH = 64,
	localparam int LZW = $clog2(SIG_WIDTH)
) (
	input  logic                                sign,
	input  logic signed [frp_pkg::EXP_W-1:0]    exponent,
	input  logic [SIG_WIDTH-1:0]                significand,
	input  logic [1:0]                          src_format,
	input  logic [1:0]                          dst_format,
	output frp_pkg::s1_ctl_t                    ctl,
	output logic [LZW-1:0]                      lz
);

	frp_pkg::fmt_t                             src_fmt;
	frp_pkg::fmt_t                             dst_fmt;
	logic signed [frp_pkg::REXP_W-1:0]         exp_ext;
	logic signed [frp_pkg::REXP_W-1:0]         bias_src;
	logic signed [frp_pkg::REXP_W-1:0]         bias_dst;

	assign src_fmt  = frp_pkg::fmt_decode(src_format);
	assign dst_fmt  = frp_pkg::fmt_decode(dst_format);
	assign exp_ext  = frp_pkg::REXP_W'(exponent);
	assign bias_src = signed'(frp_pkg::REXP_W'(frp_pkg::fmt_bias(src_fmt)));
	assign bias_dst = signed'(frp_pkg::REXP_W'(frp_pkg::fmt_bias(dst_fmt)));

	always_comb begin
		ctl.sign = sign;
		ctl.dst  = dst_fmt;
		ctl.exp  = exp_ext - bias_src + bias_dst;
		ctl.zero = ~|significand;
	end

	// highest set bit wins
	always_comb begin
		lz = '0;
		for (int i = 0; i < SIG_WIDTH; i++) begin
			if (significand[i]) begin
				lz = LZW'(SIG_WIDTH - 1 - i);
			end
		end
	end

endmodule

// ===== rtl/core/frp_align.sv =====
// Stage 2 logic: normalize, cut to target precision with guard/round/sticky, classify.
module frp_align #(
	parameter int SIG_WIDTH = 64,
	localparam int LZW = $clog2(SIG_WIDTH)
) (
	input  frp_pkg::s1_ctl_t         ctl,
	input  logic [SIG_WIDTH-1:0]     sig,
	input  logic [LZW-1:0]           lz,
	output frp_pkg::s2_t             s2
);

	localparam int NW  = (SIG_WIDTH > frp_pkg::FRAME_W) ? SIG_WIDTH : frp_pkg::FRAME_W;
	localparam int P16 = frp_pkg::MAN_B16;
	localparam int P32 = frp_pkg::MAN_B32;
	localparam int P64 = frp_pkg::MAN_B64;

	logic [SIG_WIDTH-1:0]                       norm;
	logic [NW-1:0]                              normw;
	logic signed [frp_pkg::REXP_W-1:0]          emax_s;

	assign norm   = sig << lz;
	assign normw  = NW'(norm) << (NW - SIG_WIDTH);
	assign emax_s = signed'(frp_pkg::REXP_W'(frp_pkg::fmt_emax(ctl.dst)));

	always_comb begin
		s2.sign = ctl.sign;
		s2.dst  = ctl.dst;
		s2.exp  = ctl.exp[frp_pkg::BIAS_W-1:0];

		unique case (ctl.dst)
			frp_pkg::FMT_B16: begin
				s2.man = frp_pkg::MAN_W'(normw[NW-1 -: P16+1]);
				s2.grs = {normw[NW-P16-2], normw[NW-P16-3], |normw[NW-P16-4:0]};
			end
			frp_pkg::FMT_B32: begin
				s2.man = frp_pkg::MAN_W'(normw[NW-1 -: P32+1]);
				s2.grs = {normw[NW-P32-2], normw[NW-P32-3], |normw[NW-P32-4:0]};
			end
			default: begin
				s2.man = frp_pkg::MAN_W'(normw[NW-1 -: P64+1]);
				s2.grs = {normw[NW-P64-2], normw[NW-P64-3], |normw[NW-P64-4:0]};
			end
		endcase

		priority if (ctl.zero) begin
			s2.cls = frp_pkg::CLS_ZERO;
		end else if (ctl.exp > emax_s) begin
			s2.cls = frp_pkg::CLS_OVF;
		end else if (ctl.exp < 0) begin
			s2.cls = frp_pkg::CLS_UNF;
		end else begin
			s2.cls = frp_pkg::CLS_NORM;
		end
	end

endmodule

// ===== rtl/core/frp_round.sv =====
// Stage 3 logic: rounding decision, increment with carry, overflow recheck and packing.
module frp_round (
	input  frp_pkg::s2_t    s2,
	input  logic [2:0]      rounding_mode,
	output frp_pkg::s3_t    res
);

	localparam int P16 = frp_pkg::MAN_B16;
	localparam int P32 = frp_pkg::MAN_B32;
	localparam int P64 = frp_pkg::MAN_B64;

	logic                               lsb;
	logic                               guard;
	logic                               inexact;
	logic                               inc;
	logic [frp_pkg::MAN_W:0]            sum;
	logic                               carry;
	logic [frp_pkg::MAN_B64-1:0]        frac;
	logic [frp_pkg::EMAX_W-1:0]         exp_r;
	logic [frp_pkg::WORD_W-1:0]         inf_word;

	assign lsb     = s2.man[0];
	assign guard   = s2.grs[2];
	assign inexact = |s2.grs;

	always_comb begin
		unique case (rounding_mode)
			frp_pkg::RM_RNE: inc = guard && (s2.grs[1] || s2.grs[0] || lsb);
			frp_pkg::RM_RNA: inc = guard;
			frp_pkg::RM_RUP: inc = !s2.sign && inexact;
			frp_pkg::RM_RDN: inc = s2.sign && inexact;
			default:         inc = 1'b0;
		endcase
	end

	assign sum = {1'b0, s2.man} + (frp_pkg::MAN_W+1)'(inc);

	// on carry the fraction bits are already zero
	always_comb begin
		unique case (s2.dst)
			frp_pkg::FMT_B16: begin
				carry = sum[P16+1];
				frac  = frp_pkg::MAN_B64'(sum[P16-1:0]);
			end
			frp_pkg::FMT_B32: begin
				carry = sum[P32+1];
				frac  = frp_pkg::MAN_B64'(sum[P32-1:0]);
			end
			default: begin
				carry = sum[P64+1];
				frac  = sum[P64-1:0];
			end
		endcase
	end

	assign exp_r    = frp_pkg::EMAX_W'(s2.exp) + frp_pkg::EMAX_W'(carry);
	assign inf_word = frp_pkg::pack_word(s2.dst, s2.sign, '1, '0);

	always_comb begin
		unique case (s2.cls)
			frp_pkg::CLS_ZERO: begin
				res.packed_res = frp_pkg::pack_word(s2.dst, s2.sign, '0, '0);
				res.exc        = frp_pkg::EXC_NONE;
			end
			frp_pkg::CLS_OVF: begin
				res.packed_res = inf_word;
				res.exc        = frp_pkg::EXC_OVF;
			end
			frp_pkg::CLS_UNF: begin
				res.packed_res = frp_pkg::pack_word(s2.dst, 1'b0, '1,
					frp_pkg::qnan_frac(s2.dst));
				res.exc        = frp_pkg::EXC_UNF;
			end
			default: begin
				if (exp_r > frp_pkg::fmt_emax(s2.dst)) begin
					res.packed_res = inf_word;
					res.exc        = frp_pkg::EXC_OVF;
				end else begin
					res.packed_res = frp_pkg::pack_word(s2.dst, s2.sign,
						exp_r[frp_pkg::BIAS_W-1:0], frac);
					res.exc        = frp_pkg::EXC_NONE;
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/float_round_and_pack.sv =====
// Throughput: one operand per cycle while the output is not stalled; stages are decode/leading-zero
// count, align/sticky, round/pack, and the last stage is the output register.
// A stalled output holds the pipeline in place; a stage accepts while it is empty or the one
// after it can move. arst_n clears all valid bits and sets rounding_mode to nearest even.
// Top level: three-stage round-and-pack pipeline with valid/ready channels.
module float_round_and_pack #(
	parameter int SIG_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_wdata,
	frp_in_if.sink            operand,
	frp_out_if.source         result
);

	localparam int LZW = $clog2(SIG_WIDTH);

	logic [2:0]               rounding_mode_q;

	logic                     adv1;
	logic                     adv2;
	logic                     adv3;

	frp_pkg::s1_ctl_t         ctl_d;
	logic [LZW-1:0]           lz_d;
	frp_pkg::s2_t             data_d;
	frp_pkg::s3_t             res_d;

	logic                     valid_s1;
	frp_pkg::s1_ctl_t         ctl_s1;
	logic [SIG_WIDTH-1:0]     sig_s1;
	logic [LZW-1:0]           lz_s1;
	logic                     valid_s2;
	frp_pkg::s2_t             data_s2;
	logic                     valid_s3;
	frp_pkg::s3_t             res_s3;

	assign adv3 = !valid_s3 || result.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign operand.ready     = adv1;
	assign result.valid      = valid_s3;
	assign result.packed_res = res_s3.packed_res;
	assign result.exception  = res_s3.exc;

	frp_decode #(
		.SIG_WIDTH(SIG_WIDTH)
	) u_decode (
		.sign       (operand.sign),
		.exponent   (operand.exponent),
		.significand(operand.significand[SIG_WIDTH-1:0]),
		.src_format (operand.src_format),
		.dst_format (operand.dst_format),
		.ctl        (ctl_d),
		.lz         (lz_d)
	);

	frp_align #(
		.SIG_WIDTH(SIG_WIDTH)
	) u_align (
		.ctl(ctl_s1),
		.sig(sig_s1),
		.lz (lz_s1),
		.s2 (data_d)
	);

	frp_round u_round (
		.s2           (data_s2),
		.rounding_mode(rounding_mode_q),
		.res          (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounding_mode_q <= frp_pkg::RM_RNE;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			valid_s3        <= 1'b0;
		end else begin
			if (cfg_we) begin
				rounding_mode_q <= cfg_wdata;
			end
			if (adv1) begin
				valid_s1 <= operand.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ctl_s1 <= ctl_d;
			sig_s1 <= operand.significand[SIG_WIDTH-1:0];
			lz_s1  <= lz_d;
		end
		if (adv2) begin
			data_s2 <= data_d;
		end
		if (adv3) begin
			res_s3 <= res_d;
		end
	end

endmodule

// ===== rtl/core/frp_checker.sv =====
// Port-level checks for the round-and-pack block, bound to the top level.
module frp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [frp_pkg::WORD_W-1:0]    packed_res,
	input logic [1:0]                    exception
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_res) && $stable(exception))
		else $error("result changed during stall");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input backpressure without output stall");

	a_exc_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> exception == frp_pkg::EXC_NONE || exception == frp_pkg::EXC_OVF ||
			exception == frp_pkg::EXC_UNF)
		else $error("bad exception code");

	a_ovf_is_inf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exception == frp_pkg::EXC_OVF |->
			packed_res[frp_pkg::MAN_B16-1:0] == '0)
		else $error("overflow result has nonzero fraction");

	a_accept_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> in_ready)
		else $error("input refused with empty output");

endmodule

bind float_round_and_pack frp_checker u_frp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (operand.valid),
	.in_ready  (operand.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.packed_res(result.packed_res),
	.exception (result.exception)
);
